@@ hdl/esc_pkg.sv @@
// Shared types, constants and arithmetic helpers of the sensor compensation core.
// No dependencies; every other file imports this package.
package esc_pkg;

  localparam int NumRegs = 6;
  localparam int AddrW   = 6;

  localparam logic [2:0] RegTempCal  = 3'd0;
  localparam logic [2:0] RegPressA   = 3'd1;
  localparam logic [2:0] RegPressB   = 3'd2;
  localparam logic [2:0] RegPressC   = 3'd3;
  localparam logic [2:0] RegHumA     = 3'd4;
  localparam logic [2:0] RegHumB     = 3'd5;

  localparam logic [31:0] HumMax = 32'd419430400;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] tf;
    logic        [16:0] hum;
    logic               inval;
    logic               neg;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic        [63:0] num;
    logic        [63:0] den;
    logic signed [31:0] tc;
    logic signed [31:0] tf;
    logic        [16:0] hum;
  } front_t;

  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] tf;
    logic        [16:0] hum;
    logic        [31:0] press;
    logic               inval;
  } out_t;

  typedef struct packed {
    logic signed [49:0] lo;
    logic        [31:0] hi;
  } pp_t;

  // partial products of a 64-bit word times a 17-bit signed word, modulo 2^64
  function automatic pp_t pp_mul(logic [63:0] a, logic signed [16:0] b);
    pp_t        p;
    logic [31:0] bx;
    bx   = {{15{b[16]}}, b};
    p.lo = $signed({1'b0, a[31:0]}) * b;
    p.hi = a[63:32] * bx;
    return p;
  endfunction

  function automatic logic [63:0] pp_sum(pp_t p);
    return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'd0};
  endfunction

endpackage

@@ hdl/env_sensor_compensation_core.sv @@
// Sensor compensation core: raw temperature, pressure and humidity in,
// compensated values out. Depends on esc_pkg and all esc_* modules.
//
// Input channel s_*: one raw sample set per item. Output channel m_*: one
// result item per input item, in order. The user must write calibration words
// over the APB port only while no item is in flight; the block does not enforce it.
// pready is always high. Throughput: one item per cycle while the output
// buffer is not full. The item passes 14 front stages, the 65-stage divider
// (an input stage, then one quotient bit per stage), 7 back-end stages and
// the output buffer, the first front stage being loaded at the accepting edge.
// The whole pipeline advances as one; a two-entry output buffer holds
// results while the receiver stalls, and s_tready drops only when that
// buffer is full, so no item is lost or repeated.
// Reset clears the calibration registers, all valid bits and the buffer.
// A zero pressure divisor gives press_q8 of zero with press_invalid set.
module env_sensor_compensation_core import esc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [55:0]       s_tdata,   // raw_temp, raw_press, raw_hum
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [119:0]      m_tdata,   // temp_centi, fine_temp, hum_q10, press_q8,
                                       // press_invalid, zero fill
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cal_t        cal;
  front_t      fo;
  logic        en, full;
  logic        dvalid, bvalid;
  logic [63:0] quo;
  side_t       side;
  out_t        res, dout;

  assign pready   = 1'b1;
  assign en       = !full;
  assign s_tready = en;

  esc_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cal
  );

  esc_front u_front (
    .clk, .rst, .en,
    .in_valid  (s_tvalid),
    .raw_temp  (s_tdata[19:0]),
    .raw_press (s_tdata[39:20]),
    .raw_hum   (s_tdata[55:40]),
    .cal,
    .fo
  );

  esc_div u_div (
    .clk, .rst, .en, .fo,
    .out_valid (dvalid),
    .quo,
    .side
  );

  esc_back u_back (
    .clk, .rst, .en,
    .in_valid  (dvalid),
    .quo,
    .side,
    .cal,
    .out_valid (bvalid),
    .res
  );

  esc_obuf u_obuf (
    .clk, .rst,
    .push      (en && bvalid),
    .din       (res),
    .full,
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout
  );

  assign m_tdata = {6'd0, dout.inval, dout.press, dout.hum, dout.tf, dout.tc};

endmodule

@@ hdl/esc_cfg.sv @@
// APB calibration register file of the compensation core.
// Depends on esc_pkg for register codes and the calibration struct.
module esc_cfg import esc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output cal_t              cal
);

  logic [47:0] temp_cal, press_a, press_b, press_c;
  logic [31:0] hum_a, hum_b;
  logic [2:0]  idx;

  assign idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal <= '0;
      press_a  <= '0;
      press_b  <= '0;
      press_c  <= '0;
      hum_a    <= '0;
      hum_b    <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegTempCal: temp_cal <= pwdata[47:0];
        RegPressA:  press_a  <= pwdata[47:0];
        RegPressB:  press_b  <= pwdata[47:0];
        RegPressC:  press_c  <= pwdata[47:0];
        RegHumA:    hum_a    <= pwdata[31:0];
        RegHumB:    hum_b    <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegTempCal: prdata = {16'd0, temp_cal};
      RegPressA:  prdata = {16'd0, press_a};
      RegPressB:  prdata = {16'd0, press_b};
      RegPressC:  prdata = {16'd0, press_c};
      RegHumA:    prdata = {32'd0, hum_a};
      RegHumB:    prdata = {32'd0, hum_b};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cal.t1 = temp_cal[15:0];
    cal.t2 = temp_cal[31:16];
    cal.t3 = temp_cal[47:32];
    cal.p1 = press_a[15:0];
    cal.p2 = press_a[31:16];
    cal.p3 = press_a[47:32];
    cal.p4 = press_b[15:0];
    cal.p5 = press_b[31:16];
    cal.p6 = press_b[47:32];
    cal.p7 = press_c[15:0];
    cal.p8 = press_c[31:16];
    cal.p9 = press_c[47:32];
    cal.h1 = hum_a[7:0];
    cal.h2 = hum_a[23:8];
    cal.h3 = hum_a[31:24];
    cal.h4 = hum_b[11:0];
    cal.h5 = hum_b[23:12];
    cal.h6 = hum_b[31:24];
  end

endmodule

@@ hdl/esc_front.sv @@
// Fourteen-stage front pipeline: temperature, humidity and the pressure
// dividend and divisor. Depends on esc_pkg.
module esc_front import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [19:0] raw_temp,
  input  logic [19:0] raw_press,
  input  logic [15:0] raw_hum,
  input  cal_t        cal,
  output front_t      fo
);

  logic               vld [1:14];
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic        [15:0] adch [1:6];
  logic        [20:0] pa [1:9];
  logic signed [31:0] m1, m2, ta, m3;
  logic signed [31:0] tfp [4:14];
  logic signed [31:0] tcp [5:14];
  logic signed [31:0] hv5;
  logic signed [32:0] x1_5;
  logic signed [31:0] p5v, p6v, p3v;
  logic signed [63:0] sq6;
  logic signed [48:0] m5p [6:8];
  logic signed [48:0] m2p [6:8];
  logic signed [31:0] ahp [7:10];
  logic signed [31:0] u1, u2, b1, b2, b3;
  pp_t                pp6, pp3, ppt, ppn;
  logic signed [63:0] s6, s3, x2, y9;
  logic        [63:0] t10, n0;
  logic signed [31:0] v2p [11:13];
  logic signed [31:0] sq2, w13, v3;
  logic        [63:0] zp [12:14];
  logic        [63:0] nump [12:14];
  logic        [16:0] hum14;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 14; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= 14; k++) vld[k] <= vld[k-1];
    end
  end

  always_comb begin
    v3 = v2p[13] - (w13 >>> 4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1      <= $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      d2      <= $signed({1'b0, raw_temp[19:4]}) - $signed({1'b0, cal.t1});
      adch[1] <= raw_hum;
      pa[1]   <= 21'd1048576 - {1'b0, raw_press};
      for (int k = 2; k <= 6; k++) adch[k] <= adch[k-1];
      for (int k = 2; k <= 9; k++) pa[k] <= pa[k-1];

      m1 <= d1 * cal.t2;
      m2 <= d2 * d2;
      ta <= m1 >>> 11;
      m3 <= (m2 >>> 12) * cal.t3;
      tfp[4] <= ta + (m3 >>> 14);
      for (int k = 5; k <= 14; k++) tfp[k] <= tfp[k-1];
      tcp[5] <= (tfp[4] * 32'sd5 + 32'sd128) >>> 8;
      for (int k = 6; k <= 14; k++) tcp[k] <= tcp[k-1];
      hv5  <= tfp[4] - 32'sd76800;
      x1_5 <= {tfp[4][31], tfp[4]} - 33'sd128000;

      p5v    <= cal.h5 * hv5;
      p6v    <= hv5 * cal.h6;
      p3v    <= hv5 * $signed({1'b0, cal.h3});
      sq6    <= x1_5 * x1_5;
      m5p[6] <= x1_5 * cal.p5;
      m2p[6] <= x1_5 * cal.p2;
      for (int k = 7; k <= 8; k++) begin
        m5p[k] <= m5p[k-1];
        m2p[k] <= m2p[k-1];
      end

      ahp[7] <= ($signed({2'b0, adch[6], 14'b0}) - (cal.h4 <<< 20) - p5v + 32'sd16384) >>> 15;
      for (int k = 8; k <= 10; k++) ahp[k] <= ahp[k-1];
      u1  <= p6v >>> 10;
      u2  <= (p3v >>> 11) + 32'sd32768;
      pp6 <= pp_mul(sq6, cal.p6);
      pp3 <= pp_mul(sq6, cal.p3);

      b1 <= u1 * u2;
      s6 <= $signed(pp_sum(pp6));
      s3 <= $signed(pp_sum(pp3));

      b2  <= ((b1 >>> 10) + 32'sd2097152) * cal.h2;
      x2  <= s6 + (m5p[8] <<< 17) + (cal.p4 <<< 35);
      y9  <= (s3 >>> 8) + (m2p[8] <<< 12);

      b3  <= (b2 + 32'sd8192) >>> 14;
      t10 <= y9 + (64'sd1 <<< 47);
      n0  <= ({43'd0, pa[9]} << 31) - x2;

      v2p[11] <= ahp[10] * b3;
      ppt     <= pp_mul(t10, {1'b0, cal.p1});
      ppn     <= pp_mul(n0, 17'sd3125);

      sq2      <= (v2p[11] >>> 15) * (v2p[11] >>> 15);
      v2p[12]  <= v2p[11];
      zp[12]   <= $signed(pp_sum(ppt)) >>> 33;
      nump[12] <= pp_sum(ppn);

      w13      <= (sq2 >>> 7) * $signed({1'b0, cal.h1});
      v2p[13]  <= v2p[12];
      for (int k = 13; k <= 14; k++) begin
        zp[k]   <= zp[k-1];
        nump[k] <= nump[k-1];
      end

      if (v3[31]) begin
        hum14 <= '0;
      end else if (v3 > $signed(HumMax)) begin
        hum14 <= HumMax[28:12];
      end else begin
        hum14 <= v3[28:12];
      end
    end
  end

  always_comb begin
    fo.valid = vld[14];
    fo.num   = nump[14];
    fo.den   = zp[14];
    fo.tc    = tcp[14];
    fo.tf    = tfp[14];
    fo.hum   = hum14;
  end

endmodule

@@ hdl/esc_div.sv @@
// Pipelined 64-bit restoring divider of magnitudes, one quotient bit per stage.
// Carries the side fields of each item alongside. Depends on esc_pkg.
module esc_div import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  front_t      fo,
  output logic        out_valid,
  output logic [63:0] quo,
  output side_t       side
);

  logic        vld [0:64];
  logic [63:0] rem [0:64];
  logic [63:0] nq  [0:64];
  logic [63:0] dv  [0:64];
  side_t       sd  [0:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= fo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]      <= '0;
      nq[0]       <= fo.num[63] ? 64'd0 - fo.num : fo.num;
      dv[0]       <= fo.den[63] ? 64'd0 - fo.den : fo.den;
      sd[0].tc    <= fo.tc;
      sd[0].tf    <= fo.tf;
      sd[0].hum   <= fo.hum;
      sd[0].inval <= (fo.den == 64'd0);
      sd[0].neg   <= fo.num[63] ^ fo.den[63];
    end
  end

  for (genvar k = 1; k <= 64; k++) begin : g_stage
    logic [64:0] r65, df;

    assign r65 = {rem[k-1], nq[k-1][63]};
    assign df  = r65 - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= df[64] ? r65[63:0] : df[63:0];
        nq[k]  <= {nq[k-1][62:0], ~df[64]};
        dv[k]  <= dv[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[64];
  assign quo       = nq[64];
  assign side      = sd[64];

endmodule

@@ hdl/esc_back.sv @@
// Seven-stage pressure back end: quotient sign, second-order correction,
// offset and saturation. Depends on esc_pkg.
module esc_back import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] quo,
  input  side_t       side,
  input  cal_t        cal,
  output logic        out_valid,
  output out_t        res
);

  logic               vld [0:6];
  side_t              sd [0:5];
  logic signed [63:0] q [0:4];
  logic signed [63:0] r, x2b [2:4], x1b, s5, p7x, pv;
  logic        [63:0] rll, rr;
  logic        [31:0] rhl;
  pp_t                pp8, pp9;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= 6; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= 6; k++) vld[k] <= vld[k-1];
    end
  end

  always_comb begin
    r   = q[0] >>> 13;
    p7x = cal.p7;
    pv  = (s5 >>> 8) + (p7x <<< 4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q[0]  <= side.neg ? $signed(64'd0 - quo) : $signed(quo);
      sd[0] <= side;
      for (int k = 1; k <= 5; k++) sd[k] <= sd[k-1];
      for (int k = 1; k <= 4; k++) q[k] <= q[k-1];

      rll <= r[31:0] * r[31:0];
      rhl <= r[63:32] * r[31:0];
      pp8 <= pp_mul(q[0], cal.p8);

      rr     <= rll + {rhl[30:0], 33'd0};
      x2b[2] <= $signed(pp_sum(pp8)) >>> 19;

      pp9    <= pp_mul(rr, cal.p9);
      x2b[3] <= x2b[2];

      x1b    <= $signed(pp_sum(pp9)) >>> 25;
      x2b[4] <= x2b[3];

      s5 <= q[4] + x1b + x2b[4];

      res.tc    <= sd[5].tc;
      res.tf    <= sd[5].tf;
      res.hum   <= sd[5].hum;
      res.inval <= sd[5].inval;
      if (sd[5].inval || pv[63]) begin
        res.press <= '0;
      end else if (pv[63:32] != 32'd0) begin
        res.press <= '1;
      end else begin
        res.press <= pv[31:0];
      end
    end
  end

  assign out_valid = vld[6];

endmodule

@@ hdl/esc_obuf.sv @@
// Two-entry output buffer that parts the pipeline from the result channel.
// Depends on esc_pkg for the result struct.
module esc_obuf import esc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t din,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output out_t dout
);

  logic [1:0] cnt, cnt_next, cnt_left;
  logic       pop;
  out_t       e0, e1;

  assign pop       = (cnt != 2'd0) && out_ready;
  assign cnt_left  = cnt - {1'b0, pop};
  assign cnt_next  = cnt_left + {1'b0, push};
  assign full      = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign dout      = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt_left == 2'd0)) begin
      e0 <= din;
    end else if (pop) begin
      e0 <= e1;
    end
    if (push && (cnt_left != 2'd0)) begin
      e1 <= din;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for env_sensor_compensation_core: random and directed raw sample sets
// against an in-bench integer compensation predictor, over several calibration settings.
// Depends on esc_pkg and the core RTL only.
module tb_top;
  import esc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [19:0] raw_temp;
    bit [19:0] raw_press;
    bit [15:0] raw_hum;
  } sample_t;

  typedef struct {
    bit [31:0] temp_centi;
    bit [31:0] fine_temp;
    bit [16:0] hum_q10;
    bit [31:0] press_q8;
    bit        press_invalid;
  } reading_t;

  class reading_board;
    bit [47:0] cal [NumRegs];
    reading_t  expected_readings[$];
    int        errors;

    function void write_cal(int idx, bit [63:0] value);
      if (idx < NumRegs) begin
        cal[idx] = (idx < 4) ? value[47:0] : {16'd0, value[31:0]};
      end
    endfunction

    static function bit [31:0] sr32(bit [31:0] v, int s);
      return 32'($signed(v) >>> s);
    endfunction

    static function bit [63:0] sr64(bit [63:0] v, int s);
      return 64'($signed(v) >>> s);
    endfunction

    static function bit [63:0] div64(bit [63:0] n, bit [63:0] d);
      bit [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q = an / ad;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function reading_t compensate(sample_t s);
      reading_t r;
      bit [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6, a, b, v, tf;
      bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, pv, num;
      t1 = 32'(cal[RegTempCal][15:0]);
      t2 = 32'(signed'(cal[RegTempCal][31:16]));
      t3 = 32'(signed'(cal[RegTempCal][47:32]));
      p1 = 64'(cal[RegPressA][15:0]);
      p2 = 64'(signed'(cal[RegPressA][31:16]));
      p3 = 64'(signed'(cal[RegPressA][47:32]));
      p4 = 64'(signed'(cal[RegPressB][15:0]));
      p5 = 64'(signed'(cal[RegPressB][31:16]));
      p6 = 64'(signed'(cal[RegPressB][47:32]));
      p7 = 64'(signed'(cal[RegPressC][15:0]));
      p8 = 64'(signed'(cal[RegPressC][31:16]));
      p9 = 64'(signed'(cal[RegPressC][47:32]));
      h1 = 32'(cal[RegHumA][7:0]);
      h2 = 32'(signed'(cal[RegHumA][23:8]));
      h3 = 32'(cal[RegHumA][31:24]);
      h4 = 32'(signed'(cal[RegHumB][11:0]));
      h5 = 32'(signed'(cal[RegHumB][23:12]));
      h6 = 32'(signed'(cal[RegHumB][31:24]));

      a = sr32(((32'(s.raw_temp) >> 3) - (t1 << 1)) * t2, 11);
      b = (32'(s.raw_temp) >> 4) - t1;
      b = sr32(sr32(b * b, 12) * t3, 14);
      tf = a + b;
      r.fine_temp = tf;
      r.temp_centi = sr32(tf * 32'd5 + 32'd128, 8);

      v = tf - 32'd76800;
      a = sr32((32'(s.raw_hum) << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
      b = sr32(v * h6, 10) * (sr32(v * h3, 11) + 32'd32768);
      b = (sr32(b, 10) + 32'd2097152) * h2 + 32'd8192;
      b = sr32(b, 14);
      v = a * b;
      a = sr32(v, 15);
      v = v - sr32(sr32(a * a, 7) * h1, 4);
      if (v[31]) v = 0;
      else if (v > HumMax) v = HumMax;
      r.hum_q10 = 17'(v >> 12);

      x1 = 64'(signed'(tf)) - 64'd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) << 17);
      x2 = x2 + (p4 << 35);
      x1 = sr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
      x1 = sr64(((64'd1 << 47) + x1) * p1, 33);
      if (x1 == 0) begin
        r.press_invalid = 1;
        r.press_q8 = 0;
      end else begin
        r.press_invalid = 0;
        pv = 64'd1048576 - 64'(s.raw_press);
        num = ((pv << 31) - x2) * 64'd3125;
        pv = div64(num, x1);
        x1 = sr64(p9 * sr64(pv, 13) * sr64(pv, 13), 25);
        x2 = sr64(p8 * pv, 19);
        pv = sr64(pv + x1 + x2, 8) + (p7 << 4);
        if (pv[63]) r.press_q8 = 0;
        else if (pv > 64'hFFFF_FFFF) r.press_q8 = 32'hFFFF_FFFF;
        else r.press_q8 = pv[31:0];
      end
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_readings.push_back(compensate(s));
    endfunction

    task report(string what, bit [31:0] got, bit [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (expected_readings.size() == 0) begin
        report("unexpected item", 0, 0);
        return;
      end
      want = expected_readings.pop_front();
      if (got.temp_centi != want.temp_centi) report("temp_centi", got.temp_centi, want.temp_centi);
      if (got.fine_temp != want.fine_temp) report("fine_temp", got.fine_temp, want.fine_temp);
      if (got.hum_q10 != want.hum_q10) report("hum_q10", 32'(got.hum_q10), 32'(want.hum_q10));
      if (got.press_q8 != want.press_q8) report("press_q8", got.press_q8, want.press_q8);
      if (got.press_invalid != want.press_invalid)
        report("press_invalid", 32'(got.press_invalid), 32'(want.press_invalid));
    endtask
  endclass

  localparam int CycleLimit = 400000;
  localparam int Drain = 120;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;   // raw_temp, raw_press, raw_hum
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [119:0] m_tdata;        // temp_centi, fine_temp, hum_q10, press_q8, press_invalid
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [AddrW-1:0] paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  bit           calm = 0;
  int           cycles = 0;

  reading_board board = new();

  env_sensor_compensation_core dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int idle_len();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 50);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  always @(posedge clk) begin
    reading_t got;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.note_sample('{s_tdata[19:0], s_tdata[39:20], s_tdata[55:40]});
      if (m_tvalid && m_tready) begin
        got.temp_centi = m_tdata[31:0];
        got.fine_temp = m_tdata[63:32];
        got.hum_q10 = m_tdata[80:64];
        got.press_q8 = m_tdata[112:81];
        got.press_invalid = m_tdata[113];
        board.check_reading(got);
      end
    end
  end

  initial begin
    int n;
    forever begin
      n = idle_len();
      @(negedge clk);
      m_tready = (n == 0);
      repeat (n > 0 ? n - 1 : 0) @(negedge clk);
    end
  end

  task write_reg(int idx, bit [63:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = AddrW'(idx * 8); pwdata = value;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    board.write_cal(idx, value);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task send_sample(sample_t s);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1;
    s_tdata = {s.raw_hum, s.raw_press, s.raw_temp};
    do @(posedge clk); while (!s_tready);
  endtask

  task settle();
    @(negedge clk);
    s_tvalid = 0;
    while (board.expected_readings.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    if ($urandom_range(0, 1)) begin
      s.raw_temp = 20'($urandom);
      s.raw_press = 20'($urandom);
      s.raw_hum = 16'($urandom);
    end else begin
      s.raw_temp = 20'($urandom_range(400000, 640000));
      s.raw_press = 20'($urandom_range(250000, 600000));
      s.raw_hum = 16'($urandom_range(15000, 45000));
    end
    return s;
  endfunction

  task load_typical();
    write_reg(RegTempCal, {16'hFC18, 16'd26435, 16'd27504});
    write_reg(RegPressA, {16'd3024, 16'hD643, 16'd36477});
    write_reg(RegPressB, {16'hFFF9, 16'd140, 16'd2855});
    write_reg(RegPressC, {16'd6000, 16'hC6F8, 16'd15500});
    write_reg(RegHumA, {32'd0, 8'd0, 16'd362, 8'd75});
    write_reg(RegHumB, {32'd0, 8'd30, 12'd50, 12'd313});
  endtask

  task load_random(bit extreme);
    for (int i = 0; i < NumRegs; i++)
      write_reg(i, extreme ? '1 : {$urandom, $urandom});
  endtask

  initial begin
    sample_t s;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // zero calibration: every divisor is zero
    for (int i = 0; i < 4; i++) send_sample(rand_sample());
    settle();

    load_typical();
    write_reg(NumRegs, '1);
    calm = 1;
    send_sample('{20'd0, 20'd0, 16'd0});
    send_sample('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    send_sample('{20'hFFFFF, 20'd0, 16'd0});
    send_sample('{20'd0, 20'hFFFFF, 16'hFFFF});
    send_sample('{20'd519888, 20'd415148, 16'd30000});
    send_sample('{20'd519888, 20'd415148, 16'hFFFF});
    send_sample('{20'd519888, 20'd415148, 16'd0});
    send_sample('{20'hAAAAA, 20'h55555, 16'hAAAA});
    send_sample('{20'h55555, 20'hAAAAA, 16'h5555});
    send_sample('{20'd519888, 20'd0, 16'd20000});
    calm = 0;
    for (int i = 0; i < 150; i++) send_sample(rand_sample());
    settle();

    load_random(1);
    for (int i = 0; i < 60; i++) send_sample(rand_sample());
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2) load_random(0);
      else begin
        load_typical();
        write_reg(RegHumA, {$urandom, $urandom});
        write_reg(RegPressC, {$urandom, $urandom});
      end
      calm = (ph == 3);
      for (int i = 0; i < 80; i++) send_sample(rand_sample());
      settle();
    end

    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/esc_pkg.sv
hdl/esc_cfg.sv
hdl/esc_front.sv
hdl/esc_div.sv
hdl/esc_back.sv
hdl/esc_obuf.sv
hdl/env_sensor_compensation_core.sv
tb/sv/tb_top.sv
